// ===== hdl/burgers_central_upwind_flux_unit_defines.svh =====
// Assertion helpers for the flux unit RTL; only bcuf_fin includes them.
`ifndef BURGERS_CENTRAL_UPWIND_FLUX_UNIT_DEFINES_SVH
`define BURGERS_CENTRAL_UPWIND_FLUX_UNIT_DEFINES_SVH

// Condition c must hold in the same cycle as a.
`define BCUF_ASSERT_NOW(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Condition c must hold in the cycle after a.
`define BCUF_ASSERT_NEXT(label, clk, a, c, msg) \
    label: assert property (@(posedge clk) (a) |=> (c)) else $error(msg);

`endif

// ===== hdl/bcuf_pkg.sv =====
`default_nettype none
package bcuf_pkg;
    // Flux formula chosen for one interface.
    typedef enum logic [2:0] {
        MODE_SQ_L  = 3'd0,
        MODE_SQ_R  = 3'd1,
        MODE_CROSS = 3'd2,
        MODE_ALL3  = 3'd3,
        MODE_AVG   = 3'd4
    } t_mode;

    localparam int unsigned THR_W = 31;
endpackage
`default_nettype wire

// ===== hdl/burgers_central_upwind_flux_unit.sv =====
// Central-upwind (Kurganov-Tadmor) interface flux for the 1-D Burgers equation.
// Slave stream: each beat carries the left and right reconstructed states of
// one interface, signed fixed point. Master stream: each beat carries the
// rounded, saturated numerical flux, with tuser set when it was clipped.
// The config channel writes the speed-spread threshold; below or at it the
// flux is the average of the two physical fluxes.
// The datapath is a row of three cells: sign/speed analysis, the three
// magnitude products, and summing with rounding and saturation. An accepted
// input beat is registered by each cell in turn; one beat can enter every
// cycle unless the master stalls. The multiplier cell sets the cycle time.
// Each cell has its own valid bit and takes a new beat whenever it is empty
// or its neighbor takes its beat, so bubbles collapse and a stall on the
// master side only backs up as far as it must.
// Reset (synchronous, active low) empties all cells and clears the threshold
// to zero. The config channel is always ready and should be written idle.
`default_nettype none
module burgers_central_upwind_flux_unit import bcuf_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata fields from bit 0: left_value, right_value, zero pad.
    input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // tdata fields from bit 0: interface_flux, zero pad.
    output logic [((DATA_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
    // tuser fields from bit 0: saturated.
    output logic                             m_axis_tuser,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [THR_W-1:0]            i_cfg_data
);
    localparam int W   = DATA_WIDTH;
    localparam int OTW = ((DATA_WIDTH + 7) / 8) * 8;

    logic [THR_W-1:0]  r_thr;
    logic              v1, rdy1, v2, rdy2;
    logic [W-1:0]      ml, mr, flux;
    t_mode             mode1, mode2;
    logic [2*W-1:0]    pll, plr, prr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    bcuf_prep #(.DATA_WIDTH(W)) u_prep (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_left(s_axis_tdata[W-1:0]), .i_right(s_axis_tdata[2*W-1:W]),
        .i_thr(r_thr),
        .o_valid(v1), .i_ready(rdy1),
        .o_ml(ml), .o_mr(mr), .o_mode(mode1)
    );

    bcuf_mul #(.DATA_WIDTH(W)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v1), .o_ready(rdy1),
        .i_ml(ml), .i_mr(mr), .i_mode(mode1),
        .o_valid(v2), .i_ready(rdy2),
        .o_pll(pll), .o_plr(plr), .o_prr(prr), .o_mode(mode2)
    );

    bcuf_fin #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_fin (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v2), .o_ready(rdy2),
        .i_pll(pll), .i_plr(plr), .i_prr(prr), .i_mode(mode2),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_flux(flux), .o_sat(m_axis_tuser)
    );

    assign m_axis_tdata = OTW'(flux);
endmodule
`default_nettype wire

// ===== hdl/bcuf_prep.sv =====
`default_nettype none
module bcuf_prep import bcuf_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [DATA_WIDTH-1:0] i_left,
    input  wire logic [DATA_WIDTH-1:0] i_right,
    input  wire logic [THR_W-1:0]      i_thr,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [DATA_WIDTH-1:0]      o_ml,
    output logic [DATA_WIDTH-1:0]      o_mr,
    output t_mode                      o_mode
);
    localparam int W = DATA_WIDTH;
    localparam int CW = (W > THR_W) ? W : THR_W;

    logic          negl, negr;
    logic [W-1:0]  ml, mr, pl, pr, nl, nr, apos, aneg, spread;
    logic          upwind;
    t_mode         n_mode;
    logic          r_valid;
    logic [W-1:0]  r_ml, r_mr;
    t_mode         r_mode;

    always_comb begin
        negl   = i_left[W-1];
        negr   = i_right[W-1];
        ml     = negl ? (~i_left + W'(1)) : i_left;
        mr     = negr ? (~i_right + W'(1)) : i_right;
        pl     = negl ? '0 : ml;
        pr     = negr ? '0 : mr;
        nl     = negl ? ml : '0;
        nr     = negr ? mr : '0;
        apos   = (pl > pr) ? pl : pr;
        aneg   = (nl > nr) ? nl : nr;
        spread = apos + aneg;
        upwind = CW'(spread) > CW'(i_thr);
        if (!upwind) begin
            n_mode = MODE_AVG;
        end else if (aneg == '0) begin
            n_mode = MODE_SQ_L;
        end else if (apos == '0) begin
            n_mode = MODE_SQ_R;
        end else if (negl) begin
            n_mode = MODE_CROSS;
        end else begin
            n_mode = MODE_ALL3;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ml   <= ml;
            r_mr   <= mr;
            r_mode <= n_mode;
        end
    end

    assign o_valid = r_valid;
    assign o_ml    = r_ml;
    assign o_mr    = r_mr;
    assign o_mode  = r_mode;
endmodule
`default_nettype wire

// ===== hdl/bcuf_mul.sv =====
`default_nettype none
module bcuf_mul import bcuf_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [DATA_WIDTH-1:0]   i_ml,
    input  wire logic [DATA_WIDTH-1:0]   i_mr,
    input  wire t_mode                   i_mode,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [2*DATA_WIDTH-1:0]      o_pll,
    output logic [2*DATA_WIDTH-1:0]      o_plr,
    output logic [2*DATA_WIDTH-1:0]      o_prr,
    output t_mode                        o_mode
);
    localparam int PW = 2 * DATA_WIDTH;

    logic          r_valid;
    logic [PW-1:0] r_pll, r_plr, r_prr;
    t_mode         r_mode;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Three independent unsigned products of the magnitudes.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pll  <= PW'(i_ml) * PW'(i_ml);
            r_plr  <= PW'(i_ml) * PW'(i_mr);
            r_prr  <= PW'(i_mr) * PW'(i_mr);
            r_mode <= i_mode;
        end
    end

    assign o_valid = r_valid;
    assign o_pll   = r_pll;
    assign o_plr   = r_plr;
    assign o_prr   = r_prr;
    assign o_mode  = r_mode;
endmodule
`default_nettype wire

// ===== hdl/bcuf_fin.sv =====
`default_nettype none
`include "burgers_central_upwind_flux_unit_defines.svh"
module bcuf_fin import bcuf_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [2*DATA_WIDTH-1:0] i_pll,
    input  wire logic [2*DATA_WIDTH-1:0] i_plr,
    input  wire logic [2*DATA_WIDTH-1:0] i_prr,
    input  wire t_mode                   i_mode,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [DATA_WIDTH-1:0]        o_flux,
    output logic                         o_sat
);
    localparam int W  = DATA_WIDTH;
    localparam int SW = 2 * DATA_WIDTH + 1;

    logic [SW-1:0] sum, rnd, limit;
    logic          neg, sat;
    logic [W-1:0]  mag, flux;
    logic          r_valid, r_sat;
    logic [W-1:0]  r_flux;

    always_comb begin
        case (i_mode)
            MODE_SQ_L:  sum = SW'(i_pll);
            MODE_SQ_R:  sum = SW'(i_prr);
            MODE_CROSS: sum = SW'(i_plr);
            MODE_ALL3:  sum = SW'(i_pll) + SW'(i_plr) + SW'(i_prr);
            MODE_AVG:   sum = SW'(i_pll) + SW'(i_prr);
            default:    sum = '0;
        endcase
        // Round to nearest, ties away from zero, on the magnitude.
        if (i_mode == MODE_AVG) begin
            rnd = (sum + (SW'(1) << (FRAC_BITS + 1))) >> (FRAC_BITS + 2);
        end else begin
            rnd = (sum + (SW'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
        end
        neg   = (i_mode == MODE_CROSS);
        limit = (SW'(1) << (W - 1)) - SW'(!neg);
        sat   = rnd > limit;
        mag   = sat ? limit[W-1:0] : rnd[W-1:0];
        flux  = neg ? (~mag + W'(1)) : mag;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_flux <= flux;
            r_sat  <= sat;
        end
    end

    assign o_valid = r_valid;
    assign o_flux  = r_flux;
    assign o_sat   = r_sat;

    `BCUF_ASSERT_NOW(a_sat_extreme, i_clk, i_rst_n, r_valid && r_sat, (r_flux == {1'b0, {(W-1){1'b1}}}) || (r_flux == {1'b1, {(W-1){1'b0}}}), "saturated beat not at a range limit")
    `BCUF_ASSERT_NEXT(a_take_fills, i_clk, i_rst_n && i_valid && o_ready, r_valid, "accepted beat did not reach the output register")
    `BCUF_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !r_valid, "output valid right after reset")
endmodule
`default_nettype wire
